@@ src/mrts_pkg.sv @@
// Shared types and constants for the media range token scanner.
// Used by mrts_scan and media_range_token_scanner; no dependencies.
package mrts_pkg;

  localparam int MAX_HEADER_BYTES = 1024;
  localparam int MAX_RANGES       = 16;

  localparam int POS_W  = 10;
  localparam int LEN_W  = 10;
  localparam int RIDX_W = 4;
  localparam int BC_W   = $clog2(MAX_HEADER_BYTES + 2);
  localparam int RC_W   = $clog2(MAX_RANGES + 1);

  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;

  typedef enum logic [3:0] {
    ST_WS            = 4'd0,
    ST_TYPE          = 4'd1,
    ST_TYPE_LWS      = 4'd2,
    ST_SUB_START     = 4'd3,
    ST_SUB_START_LWS = 4'd4,
    ST_SUBTYPE       = 4'd5,
    ST_SUB_LWS       = 4'd6,
    ST_PARAM         = 4'd7,
    ST_DEAD          = 4'd8
  } scan_state_t;

  typedef enum logic [2:0] {
    KIND_COMMA     = 3'd0,
    KIND_SEMI      = 3'd1,
    KIND_END       = 3'd2,
    KIND_ERROR     = 3'd3,
    KIND_END_EMPTY = 3'd4
  } report_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_UNEXPECTED = 2'd1,
    ERR_INCOMPLETE = 2'd2,
    ERR_OVERFLOW   = 2'd3
  } error_code_t;

  typedef struct packed {
    report_kind_t        kind;
    error_code_t         err;
    logic [RIDX_W-1:0]   range_index;
    logic [POS_W-1:0]    type_start;
    logic [LEN_W-1:0]    type_length;
    logic [POS_W-1:0]    subtype_start;
    logic [LEN_W-1:0]    subtype_length;
    logic                header_done;
  } report_t;

endpackage

@@ src/mrts_scan.sv @@
// Scanner state and per-byte next-state logic for the media range token scanner.
// Depends on mrts_pkg; one step is taken for each byte presented with step high.
module mrts_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [7:0]                    byte_value,
  input  logic                          last_byte,
  input  logic [mrts_pkg::POS_W-1:0]    start_offset,
  output logic                          res_valid,
  output mrts_pkg::report_t             res
);

  mrts_pkg::scan_state_t          st_r, st_nxt;
  logic [mrts_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic [mrts_pkg::POS_W-1:0]     tmark_r, tmark_nxt;
  logic [mrts_pkg::LEN_W-1:0]     tlen_r, tlen_nxt;
  logic [mrts_pkg::POS_W-1:0]     smark_r, smark_nxt;
  logic [mrts_pkg::LEN_W-1:0]     slen_r, slen_nxt;
  logic [mrts_pkg::RC_W-1:0]      rc_r, rc_nxt;
  logic [mrts_pkg::BC_W-1:0]      bc_r, bc_nxt;
  logic                           fresh_r, fresh_nxt;

  logic                           tok, lws, overflow, param_comma;
  logic                           fail_req, fin_req, empty_req;
  mrts_pkg::error_code_t          fail_code;
  mrts_pkg::report_kind_t         fin_kind;
  mrts_pkg::scan_state_t          fin_next;

  function automatic logic is_tchar(input logic [7:0] c);
    is_tchar = (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                          8'h2D, 8'h2E, 8'h21, 8'h25, 8'h2A, 8'h5F, 8'h2B,
                          8'h60, 8'h27, 8'h7E});
  endfunction

  function automatic logic is_lws(input logic [7:0] c);
    is_lws = (c inside {8'h20, 8'h09, 8'h0D, 8'h0A});
  endfunction

  function automatic logic [mrts_pkg::LEN_W-1:0] inc_sat(input logic [mrts_pkg::LEN_W-1:0] v);
    inc_sat = (&v) ? v : v + mrts_pkg::LEN_W'(1);
  endfunction

  assign tok = is_tchar(byte_value);
  assign lws = is_lws(byte_value);

  always_comb begin
    pos_nxt     = fresh_r ? start_offset : pos_r + mrts_pkg::POS_W'(1);
    bc_nxt      = (bc_r <= mrts_pkg::BC_W'(mrts_pkg::MAX_HEADER_BYTES)) ?
                  bc_r + mrts_pkg::BC_W'(1) : bc_r;
    overflow    = bc_nxt > mrts_pkg::BC_W'(mrts_pkg::MAX_HEADER_BYTES);
    fresh_nxt   = 1'b0;
    st_nxt      = st_r;
    tmark_nxt   = tmark_r;
    tlen_nxt    = tlen_r;
    smark_nxt   = smark_r;
    slen_nxt    = slen_r;
    rc_nxt      = rc_r;
    param_comma = 1'b0;
    fail_req    = 1'b0;
    fail_code   = mrts_pkg::ERR_NONE;
    fin_req     = 1'b0;
    fin_kind    = mrts_pkg::KIND_COMMA;
    fin_next    = mrts_pkg::ST_WS;
    empty_req   = 1'b0;

    // Per-byte scan, deciding at most one request.
    if (st_r != mrts_pkg::ST_DEAD && overflow) begin
      fail_req  = 1'b1;
      fail_code = mrts_pkg::ERR_OVERFLOW;
    end else begin
      case (st_r)
        mrts_pkg::ST_WS: begin
          if (tok) begin
            st_nxt    = mrts_pkg::ST_TYPE;
            tmark_nxt = pos_nxt;
            tlen_nxt  = mrts_pkg::LEN_W'(1);
          end else if (!lws) begin
            fail_req  = 1'b1;
            fail_code = mrts_pkg::ERR_UNEXPECTED;
          end
        end
        mrts_pkg::ST_TYPE: begin
          if (tok) begin
            tlen_nxt = inc_sat(tlen_r);
          end else if (lws) begin
            st_nxt = mrts_pkg::ST_TYPE_LWS;
          end else if (byte_value == mrts_pkg::CHAR_SLASH) begin
            st_nxt = mrts_pkg::ST_SUB_START;
          end else begin
            fail_req  = 1'b1;
            fail_code = mrts_pkg::ERR_UNEXPECTED;
          end
        end
        mrts_pkg::ST_TYPE_LWS: begin
          if (byte_value == mrts_pkg::CHAR_SLASH) begin
            st_nxt = mrts_pkg::ST_SUB_START;
          end else if (!lws) begin
            fail_req  = 1'b1;
            fail_code = mrts_pkg::ERR_UNEXPECTED;
          end
        end
        mrts_pkg::ST_SUB_START, mrts_pkg::ST_SUB_START_LWS: begin
          if (lws) begin
            st_nxt = mrts_pkg::ST_SUB_START_LWS;
          end else if (tok) begin
            st_nxt    = mrts_pkg::ST_SUBTYPE;
            smark_nxt = pos_nxt;
            slen_nxt  = mrts_pkg::LEN_W'(1);
          end else begin
            fail_req  = 1'b1;
            fail_code = mrts_pkg::ERR_UNEXPECTED;
          end
        end
        mrts_pkg::ST_SUBTYPE, mrts_pkg::ST_SUB_LWS: begin
          if (st_r == mrts_pkg::ST_SUBTYPE && tok) begin
            slen_nxt = inc_sat(slen_r);
          end else if (lws) begin
            st_nxt = mrts_pkg::ST_SUB_LWS;
          end else if (byte_value == mrts_pkg::CHAR_SEMI) begin
            fin_req  = 1'b1;
            fin_kind = mrts_pkg::KIND_SEMI;
            fin_next = mrts_pkg::ST_PARAM;
          end else if (byte_value == mrts_pkg::CHAR_COMMA) begin
            fin_req  = 1'b1;
            fin_kind = mrts_pkg::KIND_COMMA;
            fin_next = mrts_pkg::ST_WS;
          end else begin
            fail_req  = 1'b1;
            fail_code = mrts_pkg::ERR_UNEXPECTED;
          end
        end
        mrts_pkg::ST_PARAM: begin
          if (byte_value == mrts_pkg::CHAR_COMMA) begin
            st_nxt      = mrts_pkg::ST_WS;
            param_comma = 1'b1;
          end
        end
        default: begin
          st_nxt = mrts_pkg::ST_DEAD;
        end
      endcase
    end

    // End of header with nothing reported yet for this byte.
    if (last_byte && !fail_req && !fin_req && st_nxt != mrts_pkg::ST_DEAD) begin
      if (st_nxt == mrts_pkg::ST_PARAM || param_comma) begin
        empty_req = 1'b1;
      end else if (st_nxt == mrts_pkg::ST_SUBTYPE || st_nxt == mrts_pkg::ST_SUB_LWS) begin
        fin_req  = 1'b1;
        fin_kind = mrts_pkg::KIND_END;
        fin_next = mrts_pkg::ST_WS;
      end else begin
        fail_req  = 1'b1;
        fail_code = mrts_pkg::ERR_INCOMPLETE;
      end
    end

    // A finished range beyond the limit turns into an error.
    if (fin_req && rc_r >= mrts_pkg::RC_W'(mrts_pkg::MAX_RANGES)) begin
      fin_req   = 1'b0;
      fail_req  = 1'b1;
      fail_code = mrts_pkg::ERR_OVERFLOW;
    end

    res       = '0;
    res_valid = fail_req || fin_req || empty_req;
    if (fail_req) begin
      st_nxt   = mrts_pkg::ST_DEAD;
      res.kind = mrts_pkg::KIND_ERROR;
      res.err  = fail_code;
    end else if (fin_req) begin
      st_nxt             = fin_next;
      res.kind           = fin_kind;
      res.range_index    = rc_r[mrts_pkg::RIDX_W-1:0];
      res.type_start     = tmark_nxt;
      res.type_length    = tlen_nxt;
      res.subtype_start  = smark_nxt;
      res.subtype_length = slen_nxt;
      rc_nxt             = rc_r + mrts_pkg::RC_W'(1);
    end else if (empty_req) begin
      res.kind = mrts_pkg::KIND_END_EMPTY;
    end
    res.header_done = last_byte && res_valid;

    if (last_byte) begin
      st_nxt    = mrts_pkg::ST_WS;
      tmark_nxt = '0;
      tlen_nxt  = '0;
      smark_nxt = '0;
      slen_nxt  = '0;
      rc_nxt    = '0;
      bc_nxt    = '0;
      fresh_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= mrts_pkg::ST_WS;
      pos_r   <= '0;
      tmark_r <= '0;
      tlen_r  <= '0;
      smark_r <= '0;
      slen_r  <= '0;
      rc_r    <= '0;
      bc_r    <= '0;
      fresh_r <= 1'b1;
    end else if (step) begin
      st_r    <= st_nxt;
      pos_r   <= pos_nxt;
      tmark_r <= tmark_nxt;
      tlen_r  <= tlen_nxt;
      smark_r <= smark_nxt;
      slen_r  <= slen_nxt;
      rc_r    <= rc_nxt;
      bc_r    <= bc_nxt;
      fresh_r <= fresh_nxt;
    end
  end

`ifndef SYNTHESIS
  // The last byte of a header always leaves the scanner ready for a new header.
  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && last_byte |=> st_r == mrts_pkg::ST_WS && rc_r == '0 && fresh_r)
    else $error("scanner not restarted after last byte");

  // Without a step the scanner state and position hold.
  a_hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(st_r) && $stable(pos_r) && $stable(rc_r))
    else $error("scanner state changed without a step");

  // Every range reported mid-header advances the range count by one.
  a_range_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid && !last_byte &&
    (res.kind == mrts_pkg::KIND_COMMA || res.kind == mrts_pkg::KIND_SEMI)
    |=> rc_r == $past(rc_r) + mrts_pkg::RC_W'(1))
    else $error("range count did not advance with a reported range");
`endif

endmodule

@@ src/media_range_token_scanner.sv @@
// Top level of the media range token scanner: stream ports, input and result registers.
// Depends on mrts_pkg and mrts_scan.
//
// Usage: the header value arrives on the in_ channel one byte per beat, with in_tlast
// high on its final byte. Each byte produces zero or one report beat on the out_
// channel; out_tuser carries the report kind: a media range (ended on ',', ';' or the
// end of the header, with type and subtype offsets and lengths in out_tdata), an error,
// or an end of header that closed no new range. out_tlast marks the report made for a header's final byte.
// cfg_wr_en writes the buffer offset of the first byte of a header; it is used from
// the next header onwards and should be written while the block is idle.
// A byte accepted into the input register is scanned from there when the result register
// is free or being drained, and its report, if any, is loaded into the result register.
// Throughput is one byte per cycle while the receiver does not stall, set by the single
// scan step between the input register and the result register.
// When the receiver stalls, the pending report holds on the out_ ports and the byte
// behind it waits in the input register, whether it reports or not; in_tready drops
// only once both are occupied.
// Reset (rst_n low, synchronous) empties both registers, clears the offset to zero and
// returns the scanner to the start of a header.
module media_range_token_scanner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [1:0] error_code, [5:2] range_index,
                                  // [15:6] type_start, [25:16] type_length,
                                  // [35:26] subtype_start, [45:36] subtype_length,
                                  // [47:46] zero
  output logic [2:0]  out_tuser,  // [2:0] report_kind
  output logic        out_tlast,  // header_done
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data // start_offset
);

  logic                          in_v_r;
  logic [7:0]                    in_byte_r;
  logic                          in_last_r;
  logic                          out_v_r;
  mrts_pkg::report_t             out_res_r;
  logic [mrts_pkg::POS_W-1:0]    start_offset_r;

  logic                          step;
  logic                          res_valid;
  mrts_pkg::report_t             res;

  // The held byte is scanned whenever the result register is free or being drained.
  assign step      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || step;

  mrts_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .byte_value   (in_byte_r),
    .last_byte    (in_last_r),
    .start_offset (start_offset_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r         <= 1'b0;
      out_v_r        <= 1'b0;
      start_offset_r <= '0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (step) begin
        out_v_r <= res_valid;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        start_offset_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_res_r.header_done;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {2'b0, out_res_r.subtype_length, out_res_r.subtype_start,
                       out_res_r.type_length, out_res_r.type_start,
                       out_res_r.range_index, out_res_r.err};

`ifndef SYNTHESIS
  // Error reports carry a code and no range fields.
  a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res_r.kind == mrts_pkg::KIND_ERROR
    |-> out_res_r.err != mrts_pkg::ERR_NONE && out_res_r.range_index == '0 &&
        out_res_r.type_start == '0 && out_res_r.type_length == '0)
    else $error("error report with range fields or without a code");

  // Only error reports carry an error code.
  a_no_code_otherwise: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res_r.kind != mrts_pkg::KIND_ERROR
    |-> out_res_r.err == mrts_pkg::ERR_NONE)
    else $error("non-error report with an error code");

  // End-of-header kinds are always the last report of their header.
  a_end_kinds_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_res_r.kind == mrts_pkg::KIND_END ||
                   out_res_r.kind == mrts_pkg::KIND_END_EMPTY)
    |-> out_tlast)
    else $error("end-of-header report without header_done");
`endif

endmodule
